@@ hw/rtl/tpsd_pkg.sv @@
// ----------------------------------------------------------------------------
// tpsd_pkg
// Shared constants and types for the triangle plane slicer with
// duplicate segment removal.
// ----------------------------------------------------------------------------
package tpsd_pkg;

    // segment table geometry
    localparam int SEG_SLOTS = 1024;
    localparam int IDX_W     = $clog2(SEG_SLOTS);
    localparam int CNT_W     = $clog2(SEG_SLOTS + 1);

    // one stored segment: two points of z, y, x
    localparam int PT_W    = 96;
    localparam int ENTRY_W = 2 * PT_W;

    // on-plane tolerance register
    localparam int          TOL_W     = 20;
    localparam logic [19:0] TOL_RESET = 20'd10;

    // bits of one serial multiply or divide pass
    localparam int SER_STEPS = 33;

    // main sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_PT,
        S_LERP_GO,
        S_LERP_WAIT,
        S_SRCH,
        S_WR,
        S_OUT
    } t_state;

    // where a segment point comes from
    typedef enum logic [2:0] {
        SRC_V0,
        SRC_V1,
        SRC_V2,
        SRC_E_AB,
        SRC_E_BC,
        SRC_E_AC
    } t_src;

    // interpolation unit
    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_RND
    } t_lerp_state;

endpackage

@@ hw/rtl/tpsd_lerp.sv @@
// ----------------------------------------------------------------------------
// tpsd_lerp
// Serial edge interpolation: va + round((vb - va) * da / den), shift-add
// multiply then restoring divide, one bit per cycle, ties away from va.
// ----------------------------------------------------------------------------
module tpsd_lerp
    import tpsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_va,
    input  logic signed [31:0] i_vb,
    input  logic [32:0]        i_da,
    input  logic [33:0]        i_den,
    output logic               o_done,
    output logic signed [31:0] o_result
);

    t_lerp_state r_state, n_state;
    logic [5:0]  r_cnt;
    logic [66:0] r_p;
    logic [33:0] r_rem;
    logic [32:0] r_dq;
    logic [32:0] r_m;
    logic        r_neg;
    logic [33:0] r_den;
    logic [31:0] r_va;
    logic [31:0] r_res;
    logic        r_done;

    logic [32:0] dv;
    logic [33:0] mul_sum;
    logic [34:0] div_t;
    logic        div_ge;
    logic [34:0] div_sub;
    logic        rnd_up;
    logic [32:0] q_rnd;
    logic [33:0] res_w;

    assign dv = {i_vb[31], i_vb} - {i_va[31], i_va};

    // datapath terms
    always_comb begin
        mul_sum = r_p[66:33] + (r_p[0] ? {1'b0, r_m} : 34'd0);
        div_t   = {r_rem, r_dq[32]};
        div_ge  = div_t >= {1'b0, r_den};
        div_sub = div_t - {1'b0, r_den};
        rnd_up  = {r_rem, 1'b0} >= {1'b0, r_den};
        q_rnd   = r_dq + {32'd0, rnd_up};
        res_w   = r_neg ? ({{2{r_va[31]}}, r_va} - {1'b0, q_rnd})
                        : ({{2{r_va[31]}}, r_va} + {1'b0, q_rnd});
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE: if (i_start) n_state = L_MUL;
            L_MUL:  if (r_cnt == 6'(SER_STEPS - 1)) n_state = L_DIV;
            L_DIV:  if (r_cnt == 6'(SER_STEPS - 1)) n_state = L_RND;
            L_RND:  n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == L_RND);
            if (r_state != n_state) r_cnt <= '0;
            else                    r_cnt <= r_cnt + 6'd1;
        end
    end

    // serial multiply, divide and rounding
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            L_IDLE: begin
                r_m   <= dv[32] ? (33'd0 - dv) : dv;
                r_neg <= dv[32];
                r_va  <= i_va;
                r_den <= i_den;
                r_p   <= {34'd0, i_da};
            end
            L_MUL: begin
                r_p <= {1'b0, mul_sum, r_p[32:1]};
                if (r_cnt == 6'(SER_STEPS - 1)) begin
                    // upper product bits seed the remainder, lower ones shift in
                    r_rem <= {1'b0, mul_sum[33:1]};
                    r_dq  <= {mul_sum[0], r_p[32:1]};
                end
            end
            L_DIV: begin
                r_rem <= div_ge ? div_sub[33:0] : div_t[33:0];
                r_dq  <= {r_dq[31:0], div_ge};
            end
            L_RND: r_res <= res_w[31:0];
            default: r_res <= r_res;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

@@ hw/rtl/triangle_plane_slice_dedup_top.sv @@
// ----------------------------------------------------------------------------
// triangle_plane_slice_dedup_top
// Slices one triangle with a horizontal plane and keeps a per-layer table of
// segments so that repeated segments are flagged and not stored twice.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------
//  command  | start, busy               | i_first_x .. i_new_layer
//  result   | o_result_valid (strobe)   | o_segment_found .. o_end_z
//  config   | i_cfg_valid, o_cfg_ready  | i_cfg_data (tolerance)
//
// One triangle at a time; busy is high from the accepting beat to the result.
// With no segment the result beat follows the classification; otherwise each
// edge crossing point is interpolated one coordinate at a time (serial
// multiply then divide in the shared interpolation unit) and the table is
// searched over the stored entries of the layer.
// Synchronous active-low reset empties the table; no clearing pass.
// The result beat lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module triangle_plane_slice_dedup_top
    import tpsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_first_z,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic signed [31:0] i_second_z,
    input  logic signed [31:0] i_third_x,
    input  logic signed [31:0] i_third_y,
    input  logic signed [31:0] i_third_z,
    input  logic signed [31:0] i_plane_height,
    input  logic               i_new_layer,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [19:0]        i_cfg_data,
    output logic               o_result_valid,
    output logic               o_segment_found,
    output logic               o_is_duplicate,
    output logic               o_table_full,
    output logic signed [31:0] o_start_x,
    output logic signed [31:0] o_start_y,
    output logic signed [31:0] o_start_z,
    output logic signed [31:0] o_end_x,
    output logic signed [31:0] o_end_y,
    output logic signed [31:0] o_end_z
);

    t_state r_state, n_state;

    logic [TOL_W-1:0]           r_tol;
    logic [2:0][2:0][31:0]      r_v;      // vertex, coordinate (x, y, z)
    logic [31:0]                r_plane;
    logic [2:0][32:0]           r_ad;
    logic [1:0][2:0][31:0]      r_pt;     // point, coordinate
    t_src                       r_src0, r_src1;
    logic                       r_p;
    logic [1:0]                 r_c;
    logic                       r_found, r_dup, r_full;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           r_idx;
    logic                       r_pend;
    logic [ENTRY_W-1:0]         r_rdata;
    logic [ENTRY_W-1:0]         mem [SEG_SLOTS];

    // classification terms
    logic [2:0][32:0] d;
    logic [2:0][32:0] ad;
    logic [2:0]       on;
    logic [2:0]       pos, neg;
    logic [5:0]       cand;
    t_src             c_src0, c_src1;
    logic [1:0]       c_n;

    // point build terms
    t_src             cur_src;
    logic             cur_vtx;
    logic [1:0]       cur_vi;
    logic [1:0]       ea, eb;
    logic             lerp_start, lerp_done;
    logic [31:0]      lerp_res;

    // table terms
    logic [ENTRY_W-1:0] key_fwd, key_rev;
    logic               rd_en, hit, wr_en;

    // configuration register, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_tol <= TOL_RESET;
        else if (i_cfg_valid) r_tol <= i_cfg_data;
    end

    // heights, on-plane and crossing tests, first two point sources
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d[k]   = {r_v[k][2][31], r_v[k][2]} - {r_plane[31], r_plane};
            ad[k]  = d[k][32] ? (33'd0 - d[k]) : d[k];
            on[k]  = ad[k] <= {13'd0, r_tol};
            neg[k] = d[k][32];
            pos[k] = !d[k][32] && (d[k] != 33'd0);
        end
        cand[0] = on[0];
        cand[1] = on[1];
        cand[2] = on[2];
        cand[3] = (pos[0] && neg[1]) || (neg[0] && pos[1]);
        cand[4] = (pos[1] && neg[2]) || (neg[1] && pos[2]);
        cand[5] = (pos[0] && neg[2]) || (neg[0] && pos[2]);
        c_n    = 2'd0;
        c_src0 = SRC_V0;
        c_src1 = SRC_V0;
        for (int k = 0; k < 6; k++) begin
            if (cand[k] && c_n == 2'd0) begin
                c_src0 = t_src'(k);
                c_n    = 2'd1;
            end else if (cand[k] && c_n == 2'd1) begin
                c_src1 = t_src'(k);
                c_n    = 2'd2;
            end
        end
    end

    // current point source and edge ends
    always_comb begin
        cur_src = r_p ? r_src1 : r_src0;
        cur_vtx = 1'b0;
        cur_vi  = 2'd0;
        ea      = 2'd0;
        eb      = 2'd1;
        unique case (cur_src)
            SRC_V0:   begin cur_vtx = 1'b1; cur_vi = 2'd0; end
            SRC_V1:   begin cur_vtx = 1'b1; cur_vi = 2'd1; end
            SRC_V2:   begin cur_vtx = 1'b1; cur_vi = 2'd2; end
            SRC_E_AB: begin ea = 2'd0; eb = 2'd1; end
            SRC_E_BC: begin ea = 2'd1; eb = 2'd2; end
            SRC_E_AC: begin ea = 2'd0; eb = 2'd2; end
            default:  begin cur_vtx = 1'b1; cur_vi = 2'd0; end
        endcase
    end

    assign lerp_start = (r_state == S_LERP_GO);

    tpsd_lerp u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (lerp_start),
        .i_va     (r_v[ea][r_c]),
        .i_vb     (r_v[eb][r_c]),
        .i_da     (r_ad[ea]),
        .i_den    ({1'b0, r_ad[ea]} + {1'b0, r_ad[eb]}),
        .o_done   (lerp_done),
        .o_result (lerp_res)
    );

    // table search keys and control
    always_comb begin
        key_fwd = {r_pt[1][2], r_pt[1][1], r_pt[1][0], r_pt[0][2], r_pt[0][1], r_pt[0][0]};
        key_rev = {r_pt[0][2], r_pt[0][1], r_pt[0][0], r_pt[1][2], r_pt[1][1], r_pt[1][0]};
        hit     = r_pend && (r_rdata == key_fwd || r_rdata == key_rev);
        rd_en   = (r_state == S_SRCH) && (r_idx < r_count) && !hit;
        wr_en   = (r_state == S_WR) && (r_count != CNT_W'(SEG_SLOTS));
    end

    // segment table memory
    always_ff @(posedge i_clk) begin
        if (rd_en) r_rdata <= mem[r_idx[IDX_W-1:0]];
        if (wr_en) mem[r_count[IDX_W-1:0]] <= key_fwd;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_CLASS;
            S_CLASS: begin
                if ((on[0] && on[1] && on[2]) || c_n != 2'd2) n_state = S_OUT;
                else                                          n_state = S_PT;
            end
            S_PT: begin
                if (!cur_vtx)  n_state = S_LERP_GO;
                else if (r_p)  n_state = S_SRCH;
            end
            S_LERP_GO:   n_state = S_LERP_WAIT;
            S_LERP_WAIT: begin
                if (lerp_done && r_c != 2'd2) n_state = S_LERP_GO;
                else if (lerp_done && r_p)    n_state = S_SRCH;
                else if (lerp_done)           n_state = S_PT;
            end
            S_SRCH: begin
                if (hit)                  n_state = S_OUT;
                else if (!rd_en && !r_pend) n_state = S_WR;
            end
            S_WR:    n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_p     <= 1'b0;
            r_c     <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= rd_en;
            if (rd_en) r_idx <= r_idx + CNT_W'(1);
            if (wr_en) r_count <= r_count + CNT_W'(1);
            unique case (r_state)
                S_IDLE: begin
                    if (start && i_new_layer) r_count <= '0;
                    r_p   <= 1'b0;
                    r_c   <= '0;
                    r_idx <= '0;
                end
                S_PT: if (cur_vtx) r_p <= 1'b1;
                S_LERP_WAIT: begin
                    if (lerp_done && r_c == 2'd2) begin
                        r_c <= '0;
                        r_p <= 1'b1;
                    end else if (lerp_done) begin
                        r_c <= r_c + 2'd1;
                    end
                end
                default: r_c <= r_c;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_v     <= {i_third_z, i_third_y, i_third_x,
                            i_second_z, i_second_y, i_second_x,
                            i_first_z, i_first_y, i_first_x};
                r_plane <= i_plane_height;
            end
            S_CLASS: begin
                r_ad    <= ad;
                r_src0  <= c_src0;
                r_src1  <= c_src1;
                r_found <= !(on[0] && on[1] && on[2]) && c_n == 2'd2;
                r_dup   <= 1'b0;
                r_full  <= 1'b0;
            end
            S_PT:        if (cur_vtx) r_pt[r_p] <= r_v[cur_vi];
            S_LERP_WAIT: if (lerp_done) r_pt[r_p][r_c] <= lerp_res;
            S_SRCH:      if (hit) r_dup <= 1'b1;
            S_WR:        r_full <= !wr_en;
            default:     r_dup <= r_dup;
        endcase
    end

    // result beat
    assign busy            = (r_state != S_IDLE);
    assign o_result_valid  = (r_state == S_OUT);
    assign o_segment_found = r_found;
    assign o_is_duplicate  = r_found && r_dup;
    assign o_table_full    = r_found && r_full;
    assign o_start_x       = r_found ? r_pt[0][0] : 32'd0;
    assign o_start_y       = r_found ? r_pt[0][1] : 32'd0;
    assign o_start_z       = r_found ? r_pt[0][2] : 32'd0;
    assign o_end_x         = r_found ? r_pt[1][0] : 32'd0;
    assign o_end_y         = r_found ? r_pt[1][1] : 32'd0;
    assign o_end_z         = r_found ? r_pt[1][2] : 32'd0;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle plane slicer with duplicate removal.
// A directed table and random triangles are driven through the command port;
// every result beat is checked against a behavioral slicer with its own
// segment table and tolerance register.
// ----------------------------------------------------------------------------
module tb;
    import tpsd_pkg::*;

    localparam int N_RANDOM = 360;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] i_first_x = '0, i_first_y = '0, i_first_z = '0;
    logic signed [31:0] i_second_x = '0, i_second_y = '0, i_second_z = '0;
    logic signed [31:0] i_third_x = '0, i_third_y = '0, i_third_z = '0;
    logic signed [31:0] i_plane_height = '0;
    logic i_new_layer = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [19:0] i_cfg_data = '0;
    logic o_result_valid, o_segment_found, o_is_duplicate, o_table_full;
    logic signed [31:0] o_start_x, o_start_y, o_start_z, o_end_x, o_end_y, o_end_z;

    typedef struct {
        logic signed [31:0] c[9];
        logic signed [31:0] plane;
        logic               new_layer;
    } tri_t;

    typedef struct {
        logic found, dup, full;
        logic signed [31:0] p[6];
    } seg_t;

    seg_t seg_q[$];
    int   n_err = 0;
    int   n_seg = 0;
    int   n_beats = 0;

    // slicer state kept by the bench
    logic [19:0] tol;
    logic [95:0] tab_a[SEG_SLOTS];
    logic [95:0] tab_b[SEG_SLOTS];
    int          tab_n;

    triangle_plane_slice_dedup_top dut (.*);

    // clock
    always #5 i_clk = ~i_clk;

    // va + round((vb - va) * da / den), ties away from va
    function automatic logic signed [31:0] cross_coord(longint va, longint vb,
                                                       longint da, longint den);
        logic [95:0] prod;
        logic [95:0] q;
        logic [95:0] r;
        longint dv;
        longint m;
        dv = vb - va;
        m = dv < 0 ? -dv : dv;
        prod = 96'(m) * 96'(da);
        q = prod / 96'(den);
        r = prod % 96'(den);
        if (r >= 96'(den) - r) q = q + 1;
        return 32'(dv < 0 ? va - longint'(q) : va + longint'(q));
    endfunction

    // slice one triangle and update the segment table
    function automatic seg_t slice_triangle(tri_t t);
        seg_t s;
        longint v[3][3];
        longint d[3];
        longint ad[3];
        longint pts[2][3];
        int n;
        int ea[3];
        int eb[3];
        logic [95:0] p1, p2;
        ea = '{0, 1, 0};
        eb = '{1, 2, 2};
        n = 0;
        s.found = 0; s.dup = 0; s.full = 0;
        foreach (s.p[k]) s.p[k] = '0;
        if (t.new_layer) tab_n = 0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) v[k][j] = longint'(t.c[3*k+j]);
            d[k] = v[k][2] - longint'(t.plane);
            ad[k] = d[k] < 0 ? -d[k] : d[k];
        end
        if (ad[0] <= tol && ad[1] <= tol && ad[2] <= tol) return s;
        for (int k = 0; k < 3 && n < 2; k++)
            if (ad[k] <= tol) begin
                pts[n] = v[k];
                n++;
            end
        for (int k = 0; k < 3 && n < 2; k++) begin
            int a;
            int b;
            a = ea[k];
            b = eb[k];
            if ((d[a] > 0 && d[b] < 0) || (d[a] < 0 && d[b] > 0)) begin
                for (int j = 0; j < 3; j++)
                    pts[n][j] = cross_coord(v[a][j], v[b][j], ad[a], ad[a] + ad[b]);
                n++;
            end
        end
        if (n < 2) return s;
        s.found = 1;
        for (int j = 0; j < 3; j++) begin
            s.p[j] = 32'(pts[0][j]);
            s.p[3+j] = 32'(pts[1][j]);
        end
        p1 = {s.p[2], s.p[1], s.p[0]};
        p2 = {s.p[5], s.p[4], s.p[3]};
        for (int i = 0; i < tab_n; i++)
            if ((tab_a[i] == p1 && tab_b[i] == p2) || (tab_a[i] == p2 && tab_b[i] == p1)) begin
                s.dup = 1;
                break;
            end
        if (!s.dup) begin
            if (tab_n >= SEG_SLOTS) s.full = 1;
            else begin
                tab_a[tab_n] = p1;
                tab_b[tab_n] = p2;
                tab_n++;
            end
        end
        return s;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            seg_t e;
            logic signed [31:0] got[6];
            got = '{o_start_x, o_start_y, o_start_z, o_end_x, o_end_y, o_end_z};
            n_beats++;
            if (seg_q.size() == 0) begin
                $display("%0t unexpected result beat", $time);
                n_err++;
            end else begin
                e = seg_q.pop_front();
                if (e.found) n_seg++;
                if (o_segment_found !== e.found || o_is_duplicate !== e.dup ||
                    o_table_full !== e.full) begin
                    $display("%0t flags exp %b%b%b got %b%b%b", $time, e.found, e.dup,
                             e.full, o_segment_found, o_is_duplicate, o_table_full);
                    n_err++;
                end
                for (int k = 0; k < 6; k++)
                    if (got[k] !== e.p[k]) begin
                        $display("%0t coord %0d exp %0d got %0d", $time, k, e.p[k], got[k]);
                        n_err++;
                    end
            end
        end
    end

    task automatic wait_idle();
        while (seg_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_tol(logic [19:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tol = val;
    endtask

    // drive one triangle; fixed carries a typed-in expectation when set
    task automatic send_tri(tri_t t, bit fixed, seg_t want);
        seg_t e;
        {i_first_x, i_first_y, i_first_z} <= {t.c[0], t.c[1], t.c[2]};
        {i_second_x, i_second_y, i_second_z} <= {t.c[3], t.c[4], t.c[5]};
        {i_third_x, i_third_y, i_third_z} <= {t.c[6], t.c[7], t.c[8]};
        i_plane_height <= t.plane;
        i_new_layer <= t.new_layer;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        e = slice_triangle(t);
        if (fixed && (e.found != want.found || e.dup != want.dup ||
                      e.full != want.full || e.p != want.p)) begin
            $display("%0t table row exp found %b got model %b", $time, want.found, e.found);
            n_err++;
        end
        seg_q.insert(seg_q.size(), e);
    endtask

    function automatic logic signed [31:0] rnd_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed(32'($urandom_range(0, 4000))) - 2000;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed(32'($urandom_range(0, 2000000))) - 1000000;
        endcase
    endfunction

    function automatic tri_t rnd_tri(int layer_len, ref tri_t last);
        tri_t t;
        int mode;
        mode = $urandom_range(0, 9);
        foreach (t.c[k]) t.c[k] = rnd_coord();
        t.plane = rnd_coord();
        if (mode < 6) begin
            // plane between vertices, small deltas to hit tolerance edges
            t.plane = $signed(32'($urandom_range(0, 2000))) - 1000;
            for (int k = 0; k < 3; k++)
                t.c[3*k+2] = t.plane + ($signed(32'($urandom_range(0, 60))) - 30) *
                             ($urandom_range(0, 1) ? 1 : 1000);
        end else if (mode == 6) begin
            // repeat last triangle, sometimes with first and third vertices swapped
            t = last;
            if ($urandom_range(0, 1))
                t.c = '{last.c[6], last.c[7], last.c[8], last.c[3], last.c[4],
                        last.c[5], last.c[0], last.c[1], last.c[2]};
        end
        t.new_layer = ($urandom_range(0, layer_len) == 0);
        return t;
    endfunction

    initial begin
        tri_t t;
        tri_t last;
        seg_t none;
        seg_t any;
        tri_t rows[$];
        bit   fixed[$];
        int   gap;
        tol = TOL_RESET;
        tab_n = 0;
        none.found = 0; none.dup = 0; none.full = 0;
        foreach (none.p[k]) none.p[k] = '0;
        any = none;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows: flat, above, extremes, crossings, on-plane, duplicates
        rows.insert(rows.size(), '{'{0,0,0, 5,0,3, 0,5,-3}, 0, 1});
        rows.insert(rows.size(), '{'{1,2,100, 3,4,200, 5,6,300}, 0, 0});
        rows.insert(rows.size(), '{'{32'sh80000000,32'sh80000000,32'sh80000000,
                                     32'sh7fffffff,32'sh7fffffff,32'sh7fffffff,
                                     0,0,32'sh7fffffff}, 0, 0});
        rows.insert(rows.size(), '{'{32'sh7fffffff,32'sh80000000,32'sh7fffffff,
                                     32'sh80000000,32'sh7fffffff,32'sh80000000,
                                     0,0,0}, 32'sh80000000, 0});
        rows.insert(rows.size(), '{'{0,0,0, 10,0,100, 0,10,-100}, 0, 0});
        rows.insert(rows.size(), '{'{0,0,10, 10,0,100, 0,10,-100}, 0, 0});
        rows.insert(rows.size(), '{'{0,0,-11, 10,0,100, 0,10,-100}, 0, 0});
        rows.insert(rows.size(), '{'{0,0,0, 10,0,0, 0,10,-100}, 0, 0});
        rows.insert(rows.size(), '{'{0,0,0, 10,0,0, 0,10,-100}, 0, 0});
        rows.insert(rows.size(), '{'{0,10,-100, 10,0,0, 0,0,0}, 0, 0});
        rows.insert(rows.size(), '{'{0,0,-5, 3,0,5, 0,3,20}, 0, 0});
        rows.insert(rows.size(), '{'{0,0,-1, 1,0,2, 0,7,-2}, 0, 0});
        rows.insert(rows.size(), '{'{0,0,0, 10,0,0, 0,10,-100}, 0, 1});
        for (int i = 0; i < rows.size(); i++) fixed.insert(fixed.size(), i < 2);
        for (int i = 0; i < rows.size(); i++)
            send_tri(rows[i], fixed[i], none);
        start <= 1'b0;
        wait_idle();

        // tolerance sweep, extremes included, random phases between writes
        last = rows[0];
        for (int ph = 0; ph < 5; ph++) begin
            logic [19:0] tv[5];
            tv = '{20'd0, 20'hfffff, 20'd1000000, 20'd10, 20'($urandom_range(0, 500))};
            write_tol(tv[ph]);
            for (int i = 0; i < N_RANDOM / 5; i++) begin
                t = rnd_tri(ph == 3 ? 2000 : 40, last);
                send_tri(t, 0, any);
                last = t;
                if ($urandom_range(0, 3) == 0) begin
                    start <= 1'b0;
                    gap = $urandom_range(1, 12);
                    repeat (gap) @(posedge i_clk);
                end
            end
            start <= 1'b0;
            wait_idle();
        end

        // fill the table past its size to reach the full flag
        write_tol(20'd0);
        for (int i = 0; i < SEG_SLOTS + 4; i++) begin
            t.c = '{i, 0, -1, i + 1, 5, 1, 0, 0, 100};
            t.plane = 0;
            t.new_layer = (i == 0);
            send_tri(t, 0, any);
        end
        start <= 1'b0;
        wait_idle();

        $display("covered %0d result beats, %0d segments, five tolerance settings",
                 n_beats, n_seg);
        $display("and a table filled past %0d entries", SEG_SLOTS);
        if (n_err == 0 && seg_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit
    initial begin
        #200ms;
        $display("status: fail");
        $finish;
    end
endmodule
